// ----- rtl/mcms_pkg.sv -----
// ----------------------------------------------------------------------------
// mcms_pkg: shared types and constants for median common-mode subtraction
// Result field widths, stream widths and the control word for the cell row.
// ----------------------------------------------------------------------------
package mcms_pkg;

    localparam int IDX_W      = 6;
    localparam int CORR_W     = 14;
    localparam int CM_W       = 13;
    localparam int S_TDATA_W  = 16;
    localparam int M_FIELDS_W = IDX_W + CORR_W + CM_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic shift;
        logic insert;
    } cell_ctrl_t;

endpackage

// ----- rtl/mcms_cell.sv -----
// ----------------------------------------------------------------------------
// mcms_cell: one position of the sorting and sample-holding row
// Holds one raw sample in arrival order and one sorted sample; on insert the
// sorted value either stays, takes the new sample or takes its left neighbour.
// ----------------------------------------------------------------------------
module mcms_cell #(
    parameter int WIDTH = 12,
    parameter int IW    = 6,
    parameter int IDX   = 0
) (
    input  logic                    aclk,
    input  mcms_pkg::cell_ctrl_t    ctrl,
    input  logic [IW-1:0]           fill,
    input  logic [WIDTH-1:0]        sample,
    input  logic [WIDTH-1:0]        raw_in,
    input  logic [WIDTH-1:0]        left_val,
    input  logic                    left_gt,
    output logic [WIDTH-1:0]        raw_out,
    output logic [WIDTH-1:0]        val_out,
    output logic                    gt_out
);

    localparam logic [IW-1:0] POS = IW'(IDX);

    logic [WIDTH-1:0] raw_reg;
    logic [WIDTH-1:0] raw_next;
    logic [WIDTH-1:0] val_reg;
    logic [WIDTH-1:0] val_next;
    logic             occupied;

    // empty cells count as larger than any sample
    assign occupied = POS < fill;
    assign gt_out   = !occupied || (val_reg > sample);

    always_comb begin
        raw_next = raw_reg;
        if (ctrl.shift) begin
            raw_next = raw_in;
        end
    end

    always_comb begin
        val_next = val_reg;
        if (ctrl.insert && gt_out) begin
            if (left_gt) begin
                val_next = left_val;
            end else begin
                val_next = sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg <= raw_next;
        val_reg <= val_next;
    end

    assign raw_out = raw_reg;
    assign val_out = val_reg;

endmodule

// ----- rtl/median_common_mode_subtract_core.sv -----
// ----------------------------------------------------------------------------
// median_common_mode_subtract_core: per-chip median common-mode subtraction
// Collects one frame of ADC samples, takes the median of the frame as common
// mode and emits each sample minus the common mode in half-ADU units.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one ADC sample per beat, channels in order, CHANNELS beats
//   make a frame. Each accepted beat is sorted into a row of cells in the
//   same cycle, so input runs at one beat per cycle while collecting.
//   After the last sample, the median state adds the two middle cells to
//   form the common mode, then the frame is emitted on the m_ channel, one
//   beat per cycle while m_tready allows, in channel order, with m_tlast on
//   the final channel. Frame throughput is set by the single raw sample
//   row, which drains through its tail before the next frame fills it.
//   Input is not taken during emission.
//   The output register lets the next frame start while the last result
//   still waits. A stall on m_tready holds the output and halts emission.
//   Reset (aresetn low, synchronous) drops any partial frame and clears
//   the output valid; sample storage is not cleared.
// ----------------------------------------------------------------------------
module median_common_mode_subtract_core #(
    parameter int CHANNELS = 64,
    parameter int ADC_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // adc_sample
    input  logic [mcms_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // channel_index, corrected_half_adu, common_mode_half_adu
    output logic [mcms_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMW = ADC_BITS + 1;
    localparam int DW  = ADC_BITS + 2;
    localparam logic [IW-1:0] LAST_POS = IW'(CHANNELS - 1);

    localparam logic [1:0] ST_COLLECT = 2'd0;
    localparam logic [1:0] ST_MEDIAN  = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [IW-1:0]                     fill_reg;
    logic [IW-1:0]                     fill_next;
    logic [IW-1:0]                     emit_reg;
    logic [IW-1:0]                     emit_next;
    logic [CMW-1:0]                    cm_reg;
    logic [CMW-1:0]                    cm_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [mcms_pkg::M_TDATA_W-1:0]    m_data_reg;
    logic [mcms_pkg::M_TDATA_W-1:0]    m_data_next;
    logic                              m_last_reg;
    logic                              m_last_next;

    logic                              s_accept;
    logic                              load;
    mcms_pkg::cell_ctrl_t              ctrl;
    logic [ADC_BITS-1:0]               sample;
    logic [ADC_BITS-1:0]               raw_w [CHANNELS];
    logic [ADC_BITS-1:0]               val_w [CHANNELS];
    logic                              gt_w  [CHANNELS];

    logic signed [DW-1:0]              diff;
    logic signed [31:0]                diff_wide;
    logic [31:0]                       cm_wide;
    logic [31:0]                       idx_wide;

    assign sample   = s_tdata[ADC_BITS-1:0];
    assign s_tready = (state_reg == ST_COLLECT);
    assign s_accept = s_tvalid && s_tready;
    assign load     = (state_reg == ST_EMIT) && (!m_valid_reg || m_tready);

    assign ctrl.insert = s_accept;
    assign ctrl.shift  = s_accept || load;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        if (i == 0) begin : g_head
            mcms_cell #(
                .WIDTH (ADC_BITS),
                .IW    (IW),
                .IDX   (i)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .fill     (fill_reg),
                .sample   (sample),
                .raw_in   (sample),
                .left_val ({ADC_BITS{1'b0}}),
                .left_gt  (1'b0),
                .raw_out  (raw_w[i]),
                .val_out  (val_w[i]),
                .gt_out   (gt_w[i])
            );
        end else begin : g_body
            mcms_cell #(
                .WIDTH (ADC_BITS),
                .IW    (IW),
                .IDX   (i)
            ) u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .fill     (fill_reg),
                .sample   (sample),
                .raw_in   (raw_w[i-1]),
                .left_val (val_w[i-1]),
                .left_gt  (gt_w[i-1]),
                .raw_out  (raw_w[i]),
                .val_out  (val_w[i]),
                .gt_out   (gt_w[i])
            );
        end
    end

    // oldest sample sits at the tail of the row
    assign diff      = signed'({1'b0, raw_w[CHANNELS-1], 1'b0}) - signed'({1'b0, cm_reg});
    assign diff_wide = 32'(diff);
    assign cm_wide   = 32'(cm_reg);
    assign idx_wide  = 32'(emit_reg);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        emit_next    = emit_reg;
        cm_next      = cm_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_COLLECT: begin
                if (s_accept) begin
                    if (fill_reg == LAST_POS) begin
                        fill_next  = '0;
                        state_next = ST_MEDIAN;
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_MEDIAN: begin
                cm_next    = CMW'(val_w[CHANNELS/2-1]) + CMW'(val_w[CHANNELS/2]);
                emit_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = mcms_pkg::M_TDATA_W'({
                        cm_wide[mcms_pkg::CM_W-1:0],
                        diff_wide[mcms_pkg::CORR_W-1:0],
                        idx_wide[mcms_pkg::IDX_W-1:0]
                    });
                    m_last_next  = (emit_reg == LAST_POS);
                    if (emit_reg == LAST_POS) begin
                        emit_next  = '0;
                        state_next = ST_COLLECT;
                    end else begin
                        emit_next = emit_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            fill_reg    <= '0;
            emit_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cm_reg     <= cm_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- test/median_common_mode_subtract_core_tb.sv -----
// ----------------------------------------------------------------------------
// median_common_mode_subtract_core_tb: self-checking bench for the median core
// Sends whole frames of ADC samples on the s_ stream. A shadow of the sample
// row and of the running sort gives the common mode and the corrected value
// for every channel. Each m_ beat is checked field by field against the oldest
// expected beat. Directed frames cover the sample extremes, ties and both
// extremes of the corrected value. Random frames follow, with bursty input,
// a patterned output stall and one long output hold-off.
// ----------------------------------------------------------------------------
module median_common_mode_subtract_core_tb;

    localparam int CHANNELS    = 64;
    localparam int ADC_BITS    = 12;
    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * CHANNELS + 20;
    localparam int HOLD_CYCLES = 600;
    localparam int RAND_FRAMES = 2;
    localparam int TAIL_ITEMS  = 11;
    localparam int MAX_REPORTS = 10;
    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

    typedef enum int {
        FK_ALL_ZERO,
        FK_ALL_MAX,
        FK_LOW_HEAVY,
        FK_HIGH_HEAVY,
        FK_SPLIT,
        FK_RAMP_UP,
        FK_RAMP_DOWN,
        FK_BIT_WALK,
        FK_FULL_RANGE,
        FK_CLUSTER,
        FK_FEW_LEVELS
    } frame_kind_e;

    typedef struct {
        frame_kind_e kind;
        int          fixed_cm;
    } frame_row_t;

    typedef struct packed {
        logic [mcms_pkg::IDX_W-1:0]         idx;
        logic signed [mcms_pkg::CORR_W-1:0] corr;
        logic [mcms_pkg::CM_W-1:0]          cm;
        logic                               last;
    } cm_beat_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mcms_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mcms_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;

    // shadow of the core: samples in arrival order and the running sort
    logic [ADC_BITS-1:0] shadow_raw [CHANNELS];
    logic [ADC_BITS-1:0] shadow_sorted [CHANNELS];
    int                  shadow_fill = 0;
    cm_beat_t            pending_beats [$];

    int  err_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  quiet_sender = 1'b0;
    int  hold_asks = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  rx_mode = 0;

    // directed frames; fixed_cm of -1 means the shadow sort gives the median
    frame_row_t directed_rows [] = '{
        '{FK_LOW_HEAVY,  0},
        '{FK_HIGH_HEAVY, 8190},
        '{FK_SPLIT,      4095}
    };

    median_common_mode_subtract_core #(
        .CHANNELS (CHANNELS),
        .ADC_BITS (ADC_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic logic [ADC_BITS-1:0] frame_sample(frame_kind_e kind, int k,
                                                         logic [ADC_BITS-1:0] base);
        logic [ADC_BITS-1:0] walk;
        int                  offs;
        walk = ADC_BITS'(1) << (k % ADC_BITS);
        offs = $urandom_range(0, 40);
        case (kind)
            FK_ALL_ZERO:   return '0;
            FK_ALL_MAX:    return ADC_MAX;
            FK_LOW_HEAVY:  return (k % 2 == 1 && k < CHANNELS - 2) ? ADC_MAX : '0;
            FK_HIGH_HEAVY: return (k % 2 == 0 && k < CHANNELS - 2) ? '0 : ADC_MAX;
            FK_SPLIT:      return (k < CHANNELS / 2) ? ADC_MAX : '0;
            FK_RAMP_UP:    return ADC_BITS'(k * 65);
            FK_RAMP_DOWN:  return ADC_MAX - ADC_BITS'(k * 65);
            FK_BIT_WALK:   return (k < CHANNELS / 2) ? walk : ~walk;
            FK_CLUSTER: begin
                if (int'(base) + offs < 20) return '0;
                if (int'(base) + offs - 20 > int'(ADC_MAX)) return ADC_MAX;
                return ADC_BITS'(int'(base) + offs - 20);
            end
            FK_FEW_LEVELS: begin
                case ($urandom_range(0, 2))
                    0:       return base;
                    1:       return ~base;
                    default: return base ^ 12'h0f0;
                endcase
            end
            default:       return ADC_BITS'($urandom_range(0, int'(ADC_MAX)));
        endcase
    endfunction

    // one accepted sample: insertion sort, then a whole frame of results once full
    function automatic void take_sample(logic [ADC_BITS-1:0] v, int fixed_cm);
        int       i;
        int       diff;
        int       cm_sum;
        cm_beat_t b;
        shadow_raw[shadow_fill] = v;
        i = shadow_fill;
        while (i > 0 && shadow_sorted[i-1] > v) begin
            shadow_sorted[i] = shadow_sorted[i-1];
            i--;
        end
        shadow_sorted[i] = v;
        shadow_fill++;
        if (shadow_fill < CHANNELS) return;
        if (fixed_cm >= 0) begin
            cm_sum = fixed_cm;
        end else begin
            cm_sum = int'(shadow_sorted[CHANNELS/2-1]) + int'(shadow_sorted[CHANNELS/2]);
        end
        for (int k = 0; k < CHANNELS; k++) begin
            diff   = 2 * int'(shadow_raw[k]) - cm_sum;
            b.idx  = mcms_pkg::IDX_W'(k);
            b.corr = mcms_pkg::CORR_W'(diff);
            b.cm   = mcms_pkg::CM_W'(cm_sum);
            b.last = (k == CHANNELS - 1);
            pending_beats = {pending_beats, b};
        end
        shadow_fill = 0;
    endfunction

    task automatic push_sample(logic [ADC_BITS-1:0] v, int fixed_cm);
        int gap;
        if (burst_left == 0) begin
            gap = quiet_sender ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= mcms_pkg::S_TDATA_W'(v);
        do @(posedge aclk); while (!s_tready);
        take_sample(v, fixed_cm);
    endtask

    task automatic push_frame(frame_kind_e kind, int fixed_cm);
        logic [ADC_BITS-1:0] base;
        base = ADC_BITS'($urandom_range(0, int'(ADC_MAX)));
        quiet_sender = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < CHANNELS; k++) begin
            push_sample(frame_sample(kind, k, base), fixed_cm);
        end
    endtask

    // receiver stall pattern, with the long hold-off counted here
    always @(posedge aclk) begin
        if (cycle_count % 97 == 0) rx_mode <= $urandom_range(0, 3);
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= (cycle_count % 5 != 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        cm_beat_t want;
        cm_beat_t got;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got.idx  = m_tdata[mcms_pkg::IDX_W-1:0];
            got.corr = m_tdata[mcms_pkg::IDX_W +: mcms_pkg::CORR_W];
            got.cm   = m_tdata[mcms_pkg::IDX_W+mcms_pkg::CORR_W +: mcms_pkg::CM_W];
            got.last = m_tlast;
            if (pending_beats.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("unexpected beat: idx %0d corr %0d cm %0d last %0b",
                             got.idx, got.corr, got.cm, got.last);
                err_count++;
            end else begin
                want = pending_beats.pop_front();
                if (got != want) begin
                    if (err_count < MAX_REPORTS) begin
                        $write("beat mismatch: exp idx %0d corr %0d cm %0d last %0b, ",
                               want.idx, want.corr, want.cm, want.last);
                        $display("got idx %0d corr %0d cm %0d last %0b",
                                 got.idx, got.corr, got.cm, got.last);
                    end
                    err_count++;
                end
            end
        end
    end

    initial begin
        int hold_frame;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) push_frame(directed_rows[r].kind, directed_rows[r].fixed_cm);

        hold_frame = $urandom_range(0, RAND_FRAMES - 1);
        for (int f = 0; f < RAND_FRAMES; f++) begin
            if (f == hold_frame) hold_asks++;
            case ($urandom_range(0, 2))
                0:       push_frame(FK_FULL_RANGE, -1);
                1:       push_frame(FK_CLUSTER, -1);
                default: push_frame(FK_FEW_LEVELS, -1);
            endcase
        end

        // a partial frame at the end must give no results
        for (int k = 0; k < TAIL_ITEMS; k++)
            push_sample(ADC_BITS'($urandom_range(0, int'(ADC_MAX))), -1);
        s_tvalid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (err_count == 0 && pending_beats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
